// File: rtl/bhm_pkg.sv
`timescale 1ns / 1ps

package bhm_pkg;

   localparam int MAX_BUCKETS = 256;
   localparam int MAX_CELLS   = 8;
   localparam int BKT_W       = $clog2(MAX_BUCKETS);
   localparam int CELL_W      = $clog2(MAX_CELLS);
   localparam int ADDR_W      = BKT_W + CELL_W;
   localparam int CELL_DEPTH  = MAX_BUCKETS * MAX_CELLS;
   localparam int BC_W        = 9;
   localparam int FILL_W      = 4;
   localparam int HASH_W      = 32;
   localparam int VAL_W       = 64;
   localparam int DIGITS      = 4;   // dividend bits retired per cycle
   localparam int MOD_STEPS   = HASH_W / DIGITS;
   localparam int STEP_W      = $clog2(MOD_STEPS);

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_START_BUCKETS = 1'b0,
      CSR_CELLS         = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MOD,
      S_FILL,
      S_LCMP,
      S_GRD,
      S_GFILL,
      S_GCELL,
      S_GMOD,
      S_GEND,
      S_GHI,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] dividend;
      logic [BC_W-1:0]   divisor;
   } mod_req_type;

   typedef struct packed {
      logic            done;
      logic [BC_W-1:0] rem;
   } mod_rsp_type;

endpackage

// File: rtl/bhm_mod_unit.sv
`timescale 1ns / 1ps

module bhm_mod_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  bhm_pkg::mod_req_type mod_req,
   output bhm_pkg::mod_rsp_type mod_rsp
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [bhm_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic [bhm_pkg::HASH_W-1:0]  dvd_ff, dvd_in;
   logic [bhm_pkg::BC_W-1:0]    div_ff, div_in;
   logic [bhm_pkg::BC_W:0]      rem_ff, rem_in;

   always_comb begin
      logic [bhm_pkg::BC_W:0]     r;
      logic [bhm_pkg::HASH_W-1:0] q;
      r = rem_ff;
      q = dvd_ff;
      // restoring remainder, DIGITS bits per cycle
      for (int k = 0; k < bhm_pkg::DIGITS; k++) begin
         r = {r[bhm_pkg::BC_W-1:0], q[bhm_pkg::HASH_W-1]};
         q = {q[bhm_pkg::HASH_W-2:0], 1'b0};
         if (r >= {1'b0, div_ff}) begin
            r = r - {1'b0, div_ff};
         end
      end
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (mod_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = mod_req.dividend;
         div_in  = mod_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = q;
         rem_in = r;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bhm_pkg::STEP_W'(bhm_pkg::MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign mod_rsp.done = done_ff;
   assign mod_rsp.rem  = rem_ff[bhm_pkg::BC_W-1:0];

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mod_req.start |-> !busy_ff)
      else $error("modulo started while busy");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < {1'b0, div_ff}))
      else $error("remainder not below divisor");

endmodule

// File: rtl/bucketed_hash_map.sv
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// req       in   req_valid/req_ready  req_action, req_key_hash, req_write_value
// rsp       out  rsp_valid/rsp_ready  rsp_status, rsp_read_value, rsp_table_grew
// csr       in   csr_wr_en            csr_index, csr_wr_data
//
// One item at a time. Bucket select runs through a shared modulo unit, 4 bits
// per cycle. Lookup scans the bucket's stored cells in order, up to 8 of them.
// Doubling walks every bucket and rehashes each stored cell, then the bucket
// select runs again.
// Reset and any csr write clear the fill valid bits at once; no sweep.
// A finished beat waits in the rsp register while the next req beat is taken.

module bucketed_hash_map (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_action,
   input  logic [bhm_pkg::HASH_W-1:0]   req_key_hash,
   input  logic [bhm_pkg::VAL_W-1:0]    req_write_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [bhm_pkg::VAL_W-1:0]    rsp_read_value,
   output logic                         rsp_table_grew,
   input  logic                         csr_wr_en,
   input  logic                         csr_index,
   input  logic [bhm_pkg::BC_W-1:0]     csr_wr_data
);

   localparam int CW = bhm_pkg::HASH_W + bhm_pkg::VAL_W;

   function automatic logic [bhm_pkg::BC_W-1:0] eff_start(input logic [bhm_pkg::BC_W-1:0] v);
      if (v == '0) begin
         return bhm_pkg::BC_W'(1);
      end else if (v > bhm_pkg::BC_W'(bhm_pkg::MAX_BUCKETS)) begin
         return bhm_pkg::BC_W'(bhm_pkg::MAX_BUCKETS);
      end
      return v;
   endfunction

   function automatic logic [bhm_pkg::FILL_W-1:0] eff_cells(input logic [bhm_pkg::FILL_W-1:0] v);
      if (v == '0) begin
         return bhm_pkg::FILL_W'(1);
      end else if (v > bhm_pkg::FILL_W'(bhm_pkg::MAX_CELLS)) begin
         return bhm_pkg::FILL_W'(bhm_pkg::MAX_CELLS);
      end
      return v;
   endfunction

   bhm_pkg::state_type           state_ff, state_in;
   logic                         action_ff, action_in;
   logic [bhm_pkg::HASH_W-1:0]   hash_ff, hash_in;
   logic [bhm_pkg::VAL_W-1:0]    wval_ff, wval_in;
   logic [bhm_pkg::BKT_W-1:0]    bkt_ff, bkt_in;
   logic [bhm_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic [bhm_pkg::FILL_W-1:0]   cell_ff, cell_in;
   logic [bhm_pkg::FILL_W-1:0]   lo_ff, lo_in;
   logic [bhm_pkg::FILL_W-1:0]   hi_ff, hi_in;
   logic [bhm_pkg::BC_W-1:0]     gb_ff, gb_in;
   logic [bhm_pkg::BC_W-1:0]     bc_ff, bc_in;
   logic [bhm_pkg::BC_W-1:0]     start_ff;
   logic [bhm_pkg::FILL_W-1:0]   cells_ff;
   logic                         grew_ff, grew_in;
   bhm_pkg::status_type          res_status_ff, res_status_in;
   logic [bhm_pkg::VAL_W-1:0]    res_value_ff, res_value_in;

   logic                         rsp_valid_ff;
   logic [1:0]                   rsp_status_ff;
   logic [bhm_pkg::VAL_W-1:0]    rsp_value_ff;
   logic                         rsp_grew_ff;
   logic                         rsp_load;

   logic [CW-1:0]                cell_mem [bhm_pkg::CELL_DEPTH];
   logic [CW-1:0]                cell_rd_ff;
   logic                         cell_re, cell_we;
   logic [bhm_pkg::ADDR_W-1:0]   cell_raddr, cell_waddr;
   logic [CW-1:0]                cell_wdata;

   logic [bhm_pkg::FILL_W-1:0]   fill_mem [bhm_pkg::MAX_BUCKETS];
   logic                         fill_vld_ff [bhm_pkg::MAX_BUCKETS];
   logic [bhm_pkg::FILL_W-1:0]   fill_rd_ff;
   logic                         fill_vld_rd_ff;
   logic                         fill_re, fill_we;
   logic [bhm_pkg::BKT_W-1:0]    fill_raddr, fill_waddr;
   logic [bhm_pkg::FILL_W-1:0]   fill_wdata;
   logic [bhm_pkg::FILL_W-1:0]   fill_q;

   bhm_pkg::mod_req_type         mod_req;
   bhm_pkg::mod_rsp_type         mod_rsp;

   logic [bhm_pkg::FILL_W-1:0]   cap;
   logic [bhm_pkg::BC_W:0]       nb;
   logic                         grow_ok;
   logic [bhm_pkg::BC_W-1:0]     hi_bkt;
   logic [bhm_pkg::FILL_W-1:0]   cell_nx;

   bhm_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   assign cap     = eff_cells(cells_ff);
   assign nb      = {bc_ff, 1'b0};
   assign grow_ok = nb <= (bhm_pkg::BC_W + 1)'(bhm_pkg::MAX_BUCKETS);
   assign hi_bkt  = gb_ff + bc_ff;
   assign fill_q  = fill_vld_rd_ff ? fill_rd_ff : '0;
   assign cell_nx = cell_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bhm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      hash_in       = hash_ff;
      wval_in       = wval_ff;
      bkt_in        = bkt_ff;
      fill_in       = fill_ff;
      cell_in       = cell_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      gb_in         = gb_ff;
      bc_in         = bc_ff;
      grew_in       = grew_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      req_ready     = 1'b0;
      rsp_load      = 1'b0;
      mod_req       = '0;
      cell_re       = 1'b0;
      cell_raddr    = '0;
      cell_we       = 1'b0;
      cell_waddr    = '0;
      cell_wdata    = cell_rd_ff;
      fill_re       = 1'b0;
      fill_raddr    = '0;
      fill_we       = 1'b0;
      fill_waddr    = '0;
      fill_wdata    = '0;
      case (state_ff)
         bhm_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               action_in        = req_action;
               hash_in          = req_key_hash;
               wval_in          = req_write_value;
               grew_in          = 1'b0;
               mod_req.start    = 1'b1;
               mod_req.dividend = req_key_hash;
               mod_req.divisor  = bc_ff;
               state_in         = bhm_pkg::S_MOD;
            end
         end
         bhm_pkg::S_MOD: begin
            if (mod_rsp.done) begin
               bkt_in     = mod_rsp.rem[bhm_pkg::BKT_W-1:0];
               fill_re    = 1'b1;
               fill_raddr = mod_rsp.rem[bhm_pkg::BKT_W-1:0];
               state_in   = bhm_pkg::S_FILL;
            end
         end
         bhm_pkg::S_FILL: begin
            res_value_in = '0;
            if (action_ff) begin
               if (fill_q == '0) begin
                  res_status_in = bhm_pkg::ST_NOT_FOUND;
                  state_in      = bhm_pkg::S_DONE;
               end else begin
                  fill_in    = fill_q;
                  cell_in    = '0;
                  cell_re    = 1'b1;
                  cell_raddr = {bkt_ff, bhm_pkg::CELL_W'(0)};
                  state_in   = bhm_pkg::S_LCMP;
               end
            end else if (fill_q < cap) begin
               cell_we       = 1'b1;
               cell_waddr    = {bkt_ff, fill_q[bhm_pkg::CELL_W-1:0]};
               cell_wdata    = {hash_ff, wval_ff};
               fill_we       = 1'b1;
               fill_waddr    = bkt_ff;
               fill_wdata    = fill_q + 1'b1;
               res_status_in = bhm_pkg::ST_OK;
               state_in      = bhm_pkg::S_DONE;
            end else if (!grew_ff && grow_ok) begin
               gb_in    = '0;
               state_in = bhm_pkg::S_GRD;
            end else begin
               res_status_in = bhm_pkg::ST_FULL;
               state_in      = bhm_pkg::S_DONE;
            end
         end
         bhm_pkg::S_LCMP: begin
            if (cell_rd_ff[CW-1:bhm_pkg::VAL_W] == hash_ff) begin
               res_status_in = bhm_pkg::ST_OK;
               res_value_in  = cell_rd_ff[bhm_pkg::VAL_W-1:0];
               state_in      = bhm_pkg::S_DONE;
            end else if (cell_nx == fill_ff) begin
               res_status_in = bhm_pkg::ST_NOT_FOUND;
               state_in      = bhm_pkg::S_DONE;
            end else begin
               cell_in    = cell_nx;
               cell_re    = 1'b1;
               cell_raddr = {bkt_ff, cell_nx[bhm_pkg::CELL_W-1:0]};
            end
         end
         bhm_pkg::S_GRD: begin
            fill_re    = 1'b1;
            fill_raddr = gb_ff[bhm_pkg::BKT_W-1:0];
            state_in   = bhm_pkg::S_GFILL;
         end
         bhm_pkg::S_GFILL: begin
            fill_in = fill_q;
            lo_in   = '0;
            hi_in   = '0;
            cell_in = '0;
            if (fill_q == '0) begin
               state_in = bhm_pkg::S_GEND;
            end else begin
               cell_re    = 1'b1;
               cell_raddr = {gb_ff[bhm_pkg::BKT_W-1:0], bhm_pkg::CELL_W'(0)};
               state_in   = bhm_pkg::S_GCELL;
            end
         end
         bhm_pkg::S_GCELL: begin
            mod_req.start    = 1'b1;
            mod_req.dividend = cell_rd_ff[CW-1:bhm_pkg::VAL_W];
            mod_req.divisor  = nb[bhm_pkg::BC_W-1:0];
            state_in         = bhm_pkg::S_GMOD;
         end
         bhm_pkg::S_GMOD: begin
            if (mod_rsp.done) begin
               // target is either this bucket or its new twin; order is kept
               cell_we = 1'b1;
               if (mod_rsp.rem == gb_ff) begin
                  cell_waddr = {gb_ff[bhm_pkg::BKT_W-1:0], lo_ff[bhm_pkg::CELL_W-1:0]};
                  lo_in      = lo_ff + 1'b1;
               end else begin
                  cell_waddr = {mod_rsp.rem[bhm_pkg::BKT_W-1:0],
                                hi_ff[bhm_pkg::CELL_W-1:0]};
                  hi_in      = hi_ff + 1'b1;
               end
               cell_in = cell_nx;
               if (cell_nx < fill_ff) begin
                  cell_re    = 1'b1;
                  cell_raddr = {gb_ff[bhm_pkg::BKT_W-1:0], cell_nx[bhm_pkg::CELL_W-1:0]};
                  state_in   = bhm_pkg::S_GCELL;
               end else begin
                  state_in = bhm_pkg::S_GEND;
               end
            end
         end
         bhm_pkg::S_GEND: begin
            fill_we    = 1'b1;
            fill_waddr = gb_ff[bhm_pkg::BKT_W-1:0];
            fill_wdata = lo_ff;
            state_in   = bhm_pkg::S_GHI;
         end
         bhm_pkg::S_GHI: begin
            fill_we    = 1'b1;
            fill_waddr = hi_bkt[bhm_pkg::BKT_W-1:0];
            fill_wdata = hi_ff;
            if (gb_ff + 1'b1 == bc_ff) begin
               bc_in            = nb[bhm_pkg::BC_W-1:0];
               grew_in          = 1'b1;
               mod_req.start    = 1'b1;
               mod_req.dividend = hash_ff;
               mod_req.divisor  = nb[bhm_pkg::BC_W-1:0];
               state_in         = bhm_pkg::S_MOD;
            end else begin
               gb_in    = gb_ff + 1'b1;
               state_in = bhm_pkg::S_GRD;
            end
         end
         bhm_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = bhm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bhm_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      hash_ff       <= hash_in;
      wval_ff       <= wval_in;
      bkt_ff        <= bkt_in;
      fill_ff       <= fill_in;
      cell_ff       <= cell_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      gb_ff         <= gb_in;
      grew_ff       <= grew_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= bhm_pkg::BC_W'(16);
         cells_ff <= bhm_pkg::FILL_W'(8);
         bc_ff    <= bhm_pkg::BC_W'(16);
      end else if (csr_wr_en) begin
         if (csr_index == bhm_pkg::CSR_START_BUCKETS) begin
            start_ff <= csr_wr_data;
            bc_ff    <= eff_start(csr_wr_data);
         end else begin
            cells_ff <= csr_wr_data[bhm_pkg::FILL_W-1:0];
            bc_ff    <= eff_start(start_ff);
         end
      end else begin
         bc_ff <= bc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      if (cell_re) begin
         cell_rd_ff <= cell_mem[cell_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_waddr] <= fill_wdata;
      end
      if (fill_re) begin
         fill_rd_ff <= fill_mem[fill_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         for (int i = 0; i < bhm_pkg::MAX_BUCKETS; i++) begin
            fill_vld_ff[i] <= 1'b0;
         end
         fill_vld_rd_ff <= 1'b0;
      end else begin
         if (fill_we) begin
            fill_vld_ff[fill_waddr] <= 1'b1;
         end
         if (fill_re) begin
            fill_vld_rd_ff <= fill_vld_ff[fill_raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_grew_ff   <= grew_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_table_grew = rsp_grew_ff;

   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      fill_we |-> (fill_wdata <= cap))
      else $error("fill count above bucket capacity");

   a_bc_range: assert property (@(posedge clock) disable iff (reset)
      (bc_ff != '0) && (bc_ff <= bhm_pkg::BC_W'(bhm_pkg::MAX_BUCKETS)))
      else $error("bucket count out of range");

   a_grew_store: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_grew_ff) |-> (rsp_status_ff != bhm_pkg::ST_NOT_FOUND))
      else $error("lookup reported a doubling");

   a_grow_twice: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bhm_pkg::S_GRD) |-> !grew_ff)
      else $error("second doubling within one beat");

endmodule
